// ----- design/ddo_pkg.sv -----
package ddo_pkg;

    typedef enum logic [1:0] {
        CFG_MPC  = 2'd0,
        CFG_IWB  = 2'd1,
        CFG_RATE = 2'd2
    } t_cfg_idx;

    localparam logic signed [33:0] PI_Q29      = 34'sd1686629713;
    localparam logic signed [33:0] TWO_PI_Q29  = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314857;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

    // arctan(2^-k) in Q3.29
    function automatic logic [31:0] f_atan(input logic [4:0] k);
        logic [31:0] v;
        case (k)
            5'd0:  v = 32'd421657428;
            5'd1:  v = 32'd248918915;
            5'd2:  v = 32'd131521918;
            5'd3:  v = 32'd66762579;
            5'd4:  v = 32'd33510843;
            5'd5:  v = 32'd16771758;
            5'd6:  v = 32'd8387925;
            5'd7:  v = 32'd4194219;
            5'd8:  v = 32'd2097141;
            5'd9:  v = 32'd1048575;
            5'd10: v = 32'd524288;
            5'd11: v = 32'd262144;
            5'd12: v = 32'd131072;
            5'd13: v = 32'd65536;
            5'd14: v = 32'd32768;
            5'd15: v = 32'd16384;
            5'd16: v = 32'd8192;
            5'd17: v = 32'd4096;
            5'd18: v = 32'd2048;
            5'd19: v = 32'd1024;
            5'd20: v = 32'd512;
            5'd21: v = 32'd256;
            5'd22: v = 32'd128;
            5'd23: v = 32'd64;
            5'd24: v = 32'd32;
            5'd25: v = 32'd16;
            5'd26: v = 32'd8;
            5'd27: v = 32'd4;
            5'd28: v = 32'd2;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/ddo_if.sv -----
interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] right_count;
    logic signed [31:0] left_count;
    modport source (output valid, output right_count, output left_count, input ready);
    modport sink (input valid, input right_count, input left_count, output ready);
endinterface

interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_position;
    logic signed [31:0] y_position;
    logic signed [31:0] heading;
    logic signed [31:0] right_speed;
    logic signed [31:0] left_speed;
    logic signed [31:0] linear_speed;
    logic signed [31:0] angular_speed;
    modport source (output valid, output x_position, output y_position, output heading,
                    output right_speed, output left_speed, output linear_speed,
                    output angular_speed, input ready);
    modport sink (input valid, input x_position, input y_position, input heading,
                  input right_speed, input left_speed, input linear_speed,
                  input angular_speed, output ready);
endinterface

// ----- design/differential_drive_odometry.sv -----
// Wheel odometry for a differential-drive base. One transaction carries the right and left
// encoder counts; the block differences them against the previous counts (left negated),
// scales them to travel, reports wheel, linear and angular speed, integrates heading with a
// single wrap into [-pi, pi] and advances X and Y with saturation. Eleven scaled products
// go through one 32x32 multiplier, each in the states S_MLO, S_MHI and S_ACC. The sine
// and cosine come from an iterative CORDIC that does one rotation per cycle, started from
// S_WRAP and handed back in S_TRIG. The rest is the heading wrap, two accumulator updates
// and the output load. A new input is taken only once the previous update has finished
// and its result has been loaded into the output register. The next transaction can
// therefore be taken in the same cycle that the result appears, and a stalled output
// holds it off further.
// Configuration writes must be made while the block is idle.
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    ddo_in_if.sink      i_in,
    ddo_out_if.source   o_out
);
    import ddo_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MLO, S_MHI, S_ACC, S_ADD, S_WRAP, S_TRIG, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_PR, OP_PL, OP_PS, OP_PD, OP_VR, OP_VL, OP_VLIN, OP_DTH, OP_VANG, OP_X, OP_Y
    } t_op;

    t_state r_state;
    t_op    r_op;

    logic [31:0] r_mpc, r_iwb;
    logic [15:0] r_rate;
    logic [31:0] r_last_r, r_last_l;
    logic signed [31:0] r_x, r_y, r_hd;
    logic signed [33:0] r_dr, r_dl, r_sum, r_diff;
    logic [63:0] r_pr, r_pl, r_ps, r_pd, r_lo;
    logic signed [31:0] r_vr, r_vl, r_vlin, r_dth, r_vang, r_step, r_c, r_s;
    logic        r_ovalid;
    logic signed [31:0] r_ox, r_oy, r_ohd, r_ovr, r_ovl, r_ovlin, r_ovang;

    logic [31:0] w_drr, w_dlr;
    logic signed [33:0] w_dr, w_dl;
    logic [63:0] w_m, w_prod;
    logic [31:0] w_k, w_mul_a, w_abs_dth, w_abs_c, w_abs_s, w_negt;
    logic        w_neg, w_big;
    logic [95:0] w_full, w_t;
    logic signed [31:0] w_sat;
    logic signed [32:0] w_acc;
    logic signed [31:0] w_acc_sat;
    logic signed [33:0] w_th, w_th1, w_th2;
    logic        w_cdone;
    logic signed [31:0] w_cos, w_sin;

    function automatic logic [63:0] f_abs(input logic signed [33:0] v);
        logic signed [33:0] a;
        a = v[33] ? -v : v;
        return 64'(unsigned'(a));
    endfunction

    assign w_drr = i_in.right_count - r_last_r;
    assign w_dlr = i_in.left_count - r_last_l;
    assign w_dr  = 34'(signed'(w_drr));
    assign w_dl  = -34'(signed'(w_dlr));

    assign w_abs_dth = r_dth[31] ? 32'(-r_dth) : r_dth;
    assign w_abs_c   = r_c[31] ? 32'(-r_c) : r_c;
    assign w_abs_s   = r_s[31] ? 32'(-r_s) : r_s;

    always_comb begin
        w_m   = '0;
        w_k   = r_mpc;
        w_neg = 1'b0;
        case (r_op)
            OP_PR:   w_m = f_abs(r_dr);
            OP_PL:   w_m = f_abs(r_dl);
            OP_PS:   w_m = f_abs(r_sum);
            OP_PD:   w_m = f_abs(r_diff);
            OP_VR: begin
                w_m = r_pr; w_k = 32'(r_rate); w_neg = r_dr[33];
            end
            OP_VL: begin
                w_m = r_pl; w_k = 32'(r_rate); w_neg = r_dl[33];
            end
            OP_VLIN: begin
                w_m = r_ps; w_k = 32'(r_rate); w_neg = r_sum[33];
            end
            OP_DTH: begin
                w_m = r_pd; w_k = r_iwb; w_neg = r_diff[33];
            end
            OP_VANG: begin
                w_m = 64'(w_abs_dth); w_k = 32'(r_rate); w_neg = r_dth[31];
            end
            OP_X: begin
                w_m = r_ps; w_k = w_abs_c; w_neg = r_sum[33] ^ r_c[31];
            end
            OP_Y: begin
                w_m = r_ps; w_k = w_abs_s; w_neg = r_sum[33] ^ r_s[31];
            end
            default: w_m = '0;
        endcase
    end

    assign w_mul_a = (r_state == S_MHI) ? w_m[63:32] : w_m[31:0];

    ddo_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_k),
        .o_p   (w_prod)
    );

    assign w_full = {w_prod, 32'b0} + 96'(r_lo);

    always_comb begin
        case (r_op)
            OP_VR, OP_VL: w_t = w_full >> 16;
            OP_VLIN:      w_t = w_full >> 17;
            OP_DTH:       w_t = w_full >> 27;
            OP_VANG:      w_t = w_full >> 13;
            default:      w_t = w_full >> 47;
        endcase
    end

    // truncate on magnitude, then saturate to signed 32 bits
    assign w_big  = |w_t[95:31];
    assign w_negt = -w_t[31:0];
    assign w_sat  = w_neg ? (w_big ? 32'sh8000_0000 : signed'(w_negt))
                          : (w_big ? 32'sh7FFF_FFFF : signed'(w_t[31:0]));

    assign w_acc = ((r_op == OP_X) ? 33'(r_x) : 33'(r_y)) + 33'(r_step);
    assign w_acc_sat = (w_acc > 33'sd2147483647)  ? 32'sh7FFF_FFFF :
                       (w_acc < -33'sd2147483648) ? 32'sh8000_0000 : w_acc[31:0];

    assign w_th  = 34'(r_hd) + 34'(r_dth);
    assign w_th1 = (w_th > PI_Q29) ? w_th - TWO_PI_Q29 : w_th;
    assign w_th2 = (w_th1 < -PI_Q29) ? w_th1 + TWO_PI_Q29 : w_th1;

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_WRAP),
        .i_theta (w_th2[31:0]),
        .o_done  (w_cdone),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_PR;
            r_mpc    <= 32'd42950;
            r_iwb    <= 32'd67108864;
            r_rate   <= 16'd250;
            r_last_r <= '0;
            r_last_l <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_hd     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MPC:  r_mpc  <= i_cfg_data;
                    CFG_IWB:  r_iwb  <= i_cfg_data;
                    CFG_RATE: r_rate <= i_cfg_data[15:0];
                    default:  ;
                endcase
            end
            // S_OUT owns the output register while it loads
            if (o_out.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_dr     <= w_dr;
                        r_dl     <= w_dl;
                        r_sum    <= w_dr + w_dl;
                        r_diff   <= w_dr - w_dl;
                        r_last_r <= i_in.right_count;
                        r_last_l <= i_in.left_count;
                        r_op     <= OP_PR;
                        r_state  <= S_MLO;
                    end
                end
                S_MLO: r_state <= S_MHI;
                S_MHI: begin
                    r_lo    <= w_prod;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    case (r_op)
                        OP_PR:   r_pr   <= w_full[63:0];
                        OP_PL:   r_pl   <= w_full[63:0];
                        OP_PS:   r_ps   <= w_full[63:0];
                        OP_PD:   r_pd   <= w_full[63:0];
                        OP_VR:   r_vr   <= w_sat;
                        OP_VL:   r_vl   <= w_sat;
                        OP_VLIN: r_vlin <= w_sat;
                        OP_DTH:  r_dth  <= w_sat;
                        OP_VANG: r_vang <= w_sat;
                        default: r_step <= w_sat;
                    endcase
                    if (r_op == OP_VANG) begin
                        r_state <= S_WRAP;
                    end else if (r_op == OP_X || r_op == OP_Y) begin
                        r_state <= S_ADD;
                    end else begin
                        r_op    <= t_op'(r_op + 1'b1);
                        r_state <= S_MLO;
                    end
                end
                S_ADD: begin
                    if (r_op == OP_X) begin
                        r_x     <= w_acc_sat;
                        r_op    <= OP_Y;
                        r_state <= S_MLO;
                    end else begin
                        r_y     <= w_acc_sat;
                        r_state <= S_OUT;
                    end
                end
                S_WRAP: begin
                    r_hd    <= w_th2[31:0];
                    r_state <= S_TRIG;
                end
                S_TRIG: begin
                    if (w_cdone) begin
                        r_c     <= w_cos;
                        r_s     <= w_sin;
                        r_op    <= OP_X;
                        r_state <= S_MLO;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_ox     <= r_x;
                        r_oy     <= r_y;
                        r_ohd    <= r_hd;
                        r_ovr    <= r_vr;
                        r_ovl    <= r_vl;
                        r_ovlin  <= r_vlin;
                        r_ovang  <= r_vang;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_ovalid;
    assign o_out.x_position    = r_ox;
    assign o_out.y_position    = r_oy;
    assign o_out.heading       = r_ohd;
    assign o_out.right_speed   = r_ovr;
    assign o_out.left_speed    = r_ovl;
    assign o_out.linear_speed  = r_ovlin;
    assign o_out.angular_speed = r_ovang;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while update in flight");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (34'(o_out.heading) <= PI_Q29 && 34'(o_out.heading) >= -PI_Q29))
        else $error("heading outside [-pi, pi]");

    a_trig_resume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIG && w_cdone) |=> (r_state == S_MLO && r_op == OP_X))
        else $error("sequencer missed CORDIC completion");
endmodule

// ----- design/ddo_mul.sv -----
module ddo_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;
endmodule

// ----- design/ddo_cordic.sv -----
module ddo_cordic #(
    parameter int STEPS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_theta,
    output logic               o_done,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);
    import ddo_pkg::*;

    localparam int CW = $clog2(STEPS + 1);

    logic              r_busy, r_done, r_flip;
    logic [CW-1:0]     r_cnt;
    logic signed [33:0] r_x, r_y, r_z;
    logic signed [33:0] w_z0, w_atan, w_xs, w_ys, w_negx, w_negy;

    assign w_z0   = 34'(i_theta);
    assign w_atan = signed'({2'b00, f_atan(5'(r_cnt))});
    assign w_xs   = r_x >>> r_cnt;
    assign w_ys   = r_y >>> r_cnt;
    assign w_negx = -r_x;
    assign w_negy = -r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // fold into [-pi/2, pi/2], negate results afterwards
                if (w_z0 > HALF_PI_Q29) begin
                    r_z    <= w_z0 - PI_Q29;
                    r_flip <= 1'b1;
                end else if (w_z0 < -HALF_PI_Q29) begin
                    r_z    <= w_z0 + PI_Q29;
                    r_flip <= 1'b1;
                end else begin
                    r_z    <= w_z0;
                    r_flip <= 1'b0;
                end
                r_x    <= GAIN_Q30;
                r_y    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!r_z[33]) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_atan;
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_atan;
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? w_negx[31:0] : r_x[31:0];
    assign o_sin  = r_flip ? w_negy[31:0] : r_y[31:0];
endmodule
